[hdl/decimal_text_to_fixed_point_core_macros.svh]
// Assertion helpers for the decimal text converter.
// Each macro expects clk_i and rst_ni in the scope of its use.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_CORE_MACROS_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_CORE_MACROS_SVH

// Same-cycle implication.
`define DTFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DTFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/dtfp_pkg.sv]
`default_nettype none

package dtfp_pkg;

  // Width of the widest decimal scale (10^4)
  localparam int unsigned SCALE_W = 14;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  // Status codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd1;
  localparam logic [2:0] ERR_INT_LONG   = 3'd2;
  localparam logic [2:0] ERR_FRAC_LONG  = 3'd3;
  localparam logic [2:0] ERR_INT_DIGIT  = 3'd4;
  localparam logic [2:0] ERR_INT_RANGE  = 3'd5;
  localparam logic [2:0] ERR_FRAC_DIGIT = 3'd6;

  // Parse phase
  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_INT   = 3'b010,
    PH_FRAC  = 3'b100
  } phase_e;

  // Control state
  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_DIVIDE  = 2'b10
  } state_e;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic [2:0]         status;
  } out_item_t;

  // 10^d for a fraction of d digits
  function automatic logic [SCALE_W-1:0] dec_scale(input logic [2:0] d);
    logic [SCALE_W-1:0] s;
    unique case (d)
      3'd0:    s = 14'd1;
      3'd1:    s = 14'd10;
      3'd2:    s = 14'd100;
      3'd3:    s = 14'd1000;
      default: s = 14'd10000;
    endcase
    return s;
  endfunction

  // Keep the lowest non-zero error code
  function automatic logic [2:0] note_err(input logic [2:0] cur, input logic [2:0] code);
    logic [2:0] r;
    r = cur;
    if ((cur == ERR_NONE) || (code < cur)) begin
      r = code;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/decimal_text_to_fixed_point_core.sv]
// Input: one character per cycle while collecting; the input stalls while the
//   fraction is converted, so the next string is not taken until the result
//   is loaded. The restoring divider produces one fraction bit per cycle, the
//   final bit loads straight into the output register, and that step holds
//   while an earlier result is still stalled.
// Reset: asynchronous, active low; clears the parse state and the output valid.
`default_nettype none

`include "decimal_text_to_fixed_point_core_macros.svh"

module decimal_text_to_fixed_point_core #(
  parameter int unsigned MAX_CHARS   = 9,
  parameter int unsigned INT_DIGITS  = 3,
  parameter int unsigned FRAC_DIGITS = 4,
  parameter int unsigned INT_BITS    = 8,
  parameter int unsigned FRAC_BITS   = 7
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire dtfp_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output dtfp_pkg::out_item_t       out_data_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_CHARS + 2);
  localparam int unsigned ICNT_W = $clog2(INT_DIGITS + 1);
  localparam int unsigned FCNT_W = $clog2(FRAC_DIGITS + 1);
  localparam int unsigned INT_W  = $clog2(10 ** INT_DIGITS);
  localparam int unsigned FRAC_W = $clog2(10 ** FRAC_DIGITS);
  localparam int unsigned REM_W  = FRAC_W + 1;
  localparam int unsigned STEP_W = $clog2(FRAC_BITS + 1);
  localparam int unsigned CMP_W  = (INT_W > INT_BITS + 1) ? INT_W : INT_BITS + 1;
  localparam int unsigned MAG_W  = INT_W + FRAC_BITS;

  localparam logic [CMP_W-1:0] INT_LIMIT = CMP_W'(1) << INT_BITS;

  dtfp_pkg::state_e    state_q, state_d;
  dtfp_pkg::phase_e    phase_q, phase_d;
  logic                neg_q, neg_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [ICNT_W-1:0]   int_cnt_q, int_cnt_d;
  logic [FCNT_W-1:0]   frac_cnt_q, frac_cnt_d;
  logic [INT_W-1:0]    int_q, int_d;
  logic [REM_W-1:0]    frac_q, frac_d;
  logic [2:0]          err_q, err_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [FRAC_BITS-1:0] quot_q, quot_d;
  logic                out_valid_q, out_valid_d;
  dtfp_pkg::out_item_t out_data_q, out_data_d;

  logic                in_fire;
  logic                is_digit;
  logic [3:0]          digit;
  logic                take_int;
  logic                div_last;
  logic                out_free;
  logic                load_out;
  logic [REM_W-1:0]    scale;
  logic [REM_W-1:0]    rem_dbl;
  logic                q_bit;
  logic [REM_W-1:0]    rem_next;
  logic [FRAC_BITS:0]  quot_sh;
  logic [FRAC_BITS-1:0] quot_next;
  logic [CMP_W-1:0]    int_cmp;
  logic                range_err;
  logic [2:0]          status;
  logic [MAG_W+15:0]   mag_ext;
  logic [15:0]         mag16;
  logic                out_fault;
  logic                last_fire;
  logic                dividing;
  logic                parse_clear;

  assign in_stall_o  = (state_q != dtfp_pkg::ST_COLLECT);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Classify the incoming character
  assign is_digit = (in_data_i.character >= dtfp_pkg::CH_ZERO) &&
                    (in_data_i.character <= dtfp_pkg::CH_NINE);
  assign digit    = 4'(in_data_i.character - dtfp_pkg::CH_ZERO);

  // One restoring division step: remainder doubles, scale subtracted if it fits
  assign scale     = REM_W'(dtfp_pkg::dec_scale(3'(frac_cnt_q)));
  assign rem_dbl   = {frac_q[REM_W-2:0], 1'b0};
  assign q_bit     = (rem_dbl >= scale);
  assign rem_next  = q_bit ? (rem_dbl - scale) : rem_dbl;
  assign quot_sh   = {quot_q, q_bit};
  assign quot_next = quot_sh[FRAC_BITS-1:0];

  assign div_last = (step_q == STEP_W'(FRAC_BITS - 1));
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == dtfp_pkg::ST_DIVIDE) && div_last && out_free;

  // Final range check and result assembly
  assign int_cmp   = CMP_W'(int_q);
  assign range_err = neg_q ? (int_cmp > INT_LIMIT) : (int_cmp > (INT_LIMIT - CMP_W'(1)));
  assign status    = range_err ? dtfp_pkg::note_err(err_q, dtfp_pkg::ERR_INT_RANGE) : err_q;
  assign mag_ext   = {16'd0, int_q, quot_next};
  assign mag16     = mag_ext[15:0];

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    int_cnt_d   = int_cnt_q;
    frac_cnt_d  = frac_cnt_q;
    int_d       = int_q;
    frac_d      = frac_q;
    err_d       = err_q;
    step_d      = step_q;
    quot_d      = quot_q;
    take_int    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    unique case (state_q)
      dtfp_pkg::ST_COLLECT: begin
        if (in_fire) begin
          // Count characters, saturating one past the limit
          if (cnt_q <= CNT_W'(MAX_CHARS)) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (cnt_d > CNT_W'(MAX_CHARS)) begin
            err_d = dtfp_pkg::note_err(err_d, dtfp_pkg::ERR_TOO_LONG);
          end

          unique case (phase_q)
            dtfp_pkg::PH_START: begin
              if (in_data_i.character == dtfp_pkg::CH_PLUS) begin
                phase_d = dtfp_pkg::PH_INT;
              end else if (in_data_i.character == dtfp_pkg::CH_MINUS) begin
                neg_d   = 1'b1;
                phase_d = dtfp_pkg::PH_INT;
              end else begin
                take_int = 1'b1;
              end
            end
            dtfp_pkg::PH_INT: begin
              take_int = 1'b1;
            end
            dtfp_pkg::PH_FRAC: begin
              if (frac_cnt_q >= FCNT_W'(FRAC_DIGITS)) begin
                err_d = dtfp_pkg::note_err(err_d, dtfp_pkg::ERR_FRAC_LONG);
              end else begin
                frac_cnt_d = frac_cnt_q + FCNT_W'(1);
                if (is_digit) begin
                  frac_d = REM_W'(frac_q * REM_W'(10) + REM_W'(digit));
                end else begin
                  err_d = dtfp_pkg::note_err(err_d, dtfp_pkg::ERR_FRAC_DIGIT);
                end
              end
            end
            default: begin
            end
          endcase

          // Integer part character, or the point that ends it
          if (take_int) begin
            if (in_data_i.character == dtfp_pkg::CH_POINT) begin
              phase_d = dtfp_pkg::PH_FRAC;
            end else begin
              phase_d = dtfp_pkg::PH_INT;
              if (int_cnt_q >= ICNT_W'(INT_DIGITS)) begin
                err_d = dtfp_pkg::note_err(err_d, dtfp_pkg::ERR_INT_LONG);
              end else begin
                int_cnt_d = int_cnt_q + ICNT_W'(1);
                if (is_digit) begin
                  int_d = INT_W'(int_q * INT_W'(10) + INT_W'(digit));
                end else begin
                  err_d = dtfp_pkg::note_err(err_d, dtfp_pkg::ERR_INT_DIGIT);
                end
              end
            end
          end

          // Last character: start the fraction conversion
          if (in_data_i.last) begin
            state_d = dtfp_pkg::ST_DIVIDE;
            step_d  = '0;
          end
        end
      end

      dtfp_pkg::ST_DIVIDE: begin
        // Advance one quotient bit, holding the final one until the output is free
        if (!div_last) begin
          frac_d = rem_next;
          quot_d = quot_next;
          step_d = step_q + STEP_W'(1);
        end
        if (load_out) begin
          out_valid_d       = 1'b1;
          out_data_d.status = status;
          out_data_d.value  = (status == dtfp_pkg::ERR_NONE)
                              ? (neg_q ? (16'sd0 - $signed(mag16)) : $signed(mag16))
                              : 16'sd0;
          // Clear the parse state for the next string
          state_d    = dtfp_pkg::ST_COLLECT;
          phase_d    = dtfp_pkg::PH_START;
          neg_d      = 1'b0;
          cnt_d      = '0;
          int_cnt_d  = '0;
          frac_cnt_d = '0;
          int_d      = '0;
          frac_d     = '0;
          err_d      = dtfp_pkg::ERR_NONE;
          step_d     = '0;
        end
      end

      default: begin
        state_d = dtfp_pkg::ST_COLLECT;
      end
    endcase
  end

  // Control and parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtfp_pkg::ST_COLLECT;
      phase_q     <= dtfp_pkg::PH_START;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      int_cnt_q   <= '0;
      frac_cnt_q  <= '0;
      int_q       <= '0;
      frac_q      <= '0;
      err_q       <= dtfp_pkg::ERR_NONE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      cnt_q       <= cnt_d;
      int_cnt_q   <= int_cnt_d;
      frac_cnt_q  <= frac_cnt_d;
      int_q       <= int_d;
      frac_q      <= frac_d;
      err_q       <= err_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    quot_q     <= quot_d;
    out_data_q <= out_data_d;
  end

  // Terms watched by the checks below
  assign out_fault   = out_valid_o && (out_data_o.status != dtfp_pkg::ERR_NONE);
  assign last_fire   = in_fire && in_data_i.last;
  assign dividing    = (state_q == dtfp_pkg::ST_DIVIDE);
  assign parse_clear = (err_q == dtfp_pkg::ERR_NONE) && (cnt_q == '0);

  `DTFP_ASSERT_IMP(a_fault_zero, out_fault, out_data_o.value == 16'sd0, "non-zero faulty value")
  `DTFP_ASSERT_NXT(a_last_starts_div, last_fire, dividing, "conversion not started")
  `DTFP_ASSERT_IMP(a_step_bound, dividing, step_q <= STEP_W'(FRAC_BITS - 1), "step overrun")
  `DTFP_ASSERT_NXT(a_load_clears, load_out, out_valid_o && parse_clear, "state not cleared")

endmodule

`default_nettype wire

[sim/decimal_text_to_fixed_point_core_checker.sv]
`timescale 1ns / 1ps

module decimal_text_to_fixed_point_core_checker #(
  parameter int unsigned MAX_CHARS   = 9,
  parameter int unsigned INT_DIGITS  = 3,
  parameter int unsigned FRAC_DIGITS = 4,
  parameter int unsigned INT_BITS    = 8,
  parameter int unsigned FRAC_BITS   = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  dtfp_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  dtfp_pkg::out_item_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  results_o,
  output logic [6:0]          status_seen_o
);

  // Parse state of the text being read
  logic             neg_q;
  dtfp_pkg::phase_e phase_q;
  logic [3:0]       chars_q;
  logic [2:0]       int_cnt_q;
  logic [2:0]       frac_cnt_q;
  logic [9:0]       int_acc_q;
  logic [13:0]      frac_acc_q;
  logic [2:0]       fault_q;

  // Conversions still owed by the block, oldest first
  dtfp_pkg::out_item_t conv_q[$];
  dtfp_pkg::out_item_t oldest_conv;

  // Keep the lowest non-zero fault code
  function automatic logic [2:0] keep_lowest_fault(input logic [2:0] cur,
                                                   input logic [2:0] code);
    if ((cur == dtfp_pkg::ERR_NONE) || (code < cur)) begin
      return code;
    end
    return cur;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= dtfp_pkg::CH_ZERO) && (ch <= dtfp_pkg::CH_NINE);
  endfunction

  task automatic clear_parse();
    neg_q      = 1'b0;
    phase_q    = dtfp_pkg::PH_START;
    chars_q    = '0;
    int_cnt_q  = '0;
    frac_cnt_q = '0;
    int_acc_q  = '0;
    frac_acc_q = '0;
    fault_q    = dtfp_pkg::ERR_NONE;
  endtask

  // Integer part: a point moves on to the fraction
  task automatic take_int_char(input logic [7:0] ch);
    if (ch == dtfp_pkg::CH_POINT) begin
      phase_q = dtfp_pkg::PH_FRAC;
    end else begin
      phase_q = dtfp_pkg::PH_INT;
      if (int_cnt_q >= INT_DIGITS) begin
        fault_q = keep_lowest_fault(fault_q, dtfp_pkg::ERR_INT_LONG);
      end else begin
        int_cnt_q = int_cnt_q + 1'b1;
        if (is_digit(ch)) begin
          int_acc_q = 10'(int_acc_q * 10 + (ch - dtfp_pkg::CH_ZERO));
        end else begin
          fault_q = keep_lowest_fault(fault_q, dtfp_pkg::ERR_INT_DIGIT);
        end
      end
    end
  endtask

  // Advance the parse by one character; on the last one, queue the conversion
  task automatic parse_char(input logic [7:0] ch, input logic last_ch);
    logic [31:0]         scale;
    logic [31:0]         frac_bin;
    logic [31:0]         mag;
    dtfp_pkg::out_item_t conv;
    int                  i;
    if (chars_q <= MAX_CHARS) begin
      chars_q = chars_q + 1'b1;
    end
    if (chars_q > MAX_CHARS) begin
      fault_q = keep_lowest_fault(fault_q, dtfp_pkg::ERR_TOO_LONG);
    end

    case (phase_q)
      dtfp_pkg::PH_START: begin
        if (ch == dtfp_pkg::CH_PLUS) begin
          phase_q = dtfp_pkg::PH_INT;
        end else if (ch == dtfp_pkg::CH_MINUS) begin
          neg_q   = 1'b1;
          phase_q = dtfp_pkg::PH_INT;
        end else begin
          take_int_char(ch);
        end
      end
      dtfp_pkg::PH_INT: begin
        take_int_char(ch);
      end
      default: begin
        if (frac_cnt_q >= FRAC_DIGITS) begin
          fault_q = keep_lowest_fault(fault_q, dtfp_pkg::ERR_FRAC_LONG);
        end else begin
          frac_cnt_q = frac_cnt_q + 1'b1;
          if (is_digit(ch)) begin
            frac_acc_q = 14'(frac_acc_q * 10 + (ch - dtfp_pkg::CH_ZERO));
          end else begin
            fault_q = keep_lowest_fault(fault_q, dtfp_pkg::ERR_FRAC_DIGIT);
          end
        end
      end
    endcase

    if (last_ch) begin
      // Range: a negative integer may reach 2^INT_BITS, a positive one not
      mag = 32'd1 << INT_BITS;
      if (neg_q ? (int_acc_q > mag) : (int_acc_q > mag - 1)) begin
        fault_q = keep_lowest_fault(fault_q, dtfp_pkg::ERR_INT_RANGE);
      end
      conv.status = fault_q;
      conv.value  = '0;
      if (fault_q == dtfp_pkg::ERR_NONE) begin
        // Truncate f * 2^FRAC_BITS / 10^digits
        scale = 32'd1;
        for (i = 0; i < frac_cnt_q; i++) begin
          scale = scale * 10;
        end
        frac_bin = 32'(frac_acc_q);
        frac_bin = (frac_bin << FRAC_BITS) / scale;
        mag      = 32'(int_acc_q);
        mag      = (mag << FRAC_BITS) | frac_bin;
        if (neg_q) begin
          mag = -mag;
        end
        conv.value = mag[15:0];
      end
      conv_q.push_back(conv);
      status_seen_o[conv.status] = 1'b1;
      clear_parse();
    end
  endtask

  task automatic report_fault(input string msg);
    if (fail_count_o < 10) begin
      $display("checker: %s", msg);
    end
    fail_count_o++;
  endtask

  // Predict on every accepted character, compare every accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      conv_q.delete();
      fail_count_o  = 0;
      results_o     = 0;
      status_seen_o = '0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        parse_char(in_data_i.character, in_data_i.last);
      end
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (conv_q.size() == 0) begin
          report_fault($sformatf("result with nothing owed: value %0d status %0d",
                                 out_data_i.value, out_data_i.status));
        end else begin
          oldest_conv = conv_q.pop_front();
          if (out_data_i.value !== oldest_conv.value) begin
            report_fault($sformatf("result %0d value: expected %0d, got %0d", results_o,
                                   oldest_conv.value, out_data_i.value));
          end
          if (out_data_i.status !== oldest_conv.status) begin
            report_fault($sformatf("result %0d status: expected %0d, got %0d", results_o,
                                   oldest_conv.status, out_data_i.status));
          end
        end
      end
      pending_o <= conv_q.size();
    end
  end

endmodule

[sim/decimal_text_to_fixed_point_core_tb.sv]
`timescale 1ns / 1ps

module decimal_text_to_fixed_point_core_tb;

  localparam int unsigned MAX_CHARS   = 9;
  localparam int unsigned INT_DIGITS  = 3;
  localparam int unsigned FRAC_DIGITS = 4;
  localparam int unsigned INT_BITS    = 8;
  localparam int unsigned FRAC_BITS   = 7;

  localparam int RANDOM_CHARS   = 1550;
  localparam int TEXTS_PER_RUN  = 40;
  localparam int TAIL_CYCLES    = FRAC_BITS + 12;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  dtfp_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  dtfp_pkg::out_item_t out_data;

  int         fail_count;
  int         pending;
  int         results;
  logic [6:0] status_seen;

  int         chars_sent = 0;
  int         texts_sent = 0;
  int         stuck_cycles;
  logic       send_idle = 1'b1;
  logic       recv_idle = 1'b1;
  logic [7:0] text_q[$];

  decimal_text_to_fixed_point_core #(
    .MAX_CHARS  (MAX_CHARS),
    .INT_DIGITS (INT_DIGITS),
    .FRAC_DIGITS(FRAC_DIGITS),
    .INT_BITS   (INT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  decimal_text_to_fixed_point_core_checker #(
    .MAX_CHARS  (MAX_CHARS),
    .INT_DIGITS (INT_DIGITS),
    .FRAC_DIGITS(FRAC_DIGITS),
    .INT_BITS   (INT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .status_seen_o(status_seen)
  );

  always #5 clk = ~clk;

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("decimal_text_to_fixed_point_core_tb: done, errors");
        $finish;
      end
    end
  end

  // Result side: hold stall for a random gap, then take one item
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = recv_idle ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  function automatic logic [7:0] rand_digit();
    logic [7:0] d;
    d = 8'($urandom_range(0, 9));
    return dtfp_pkg::CH_ZERO + d;
  endfunction

  // Mostly characters the parser cares about, some arbitrary bytes
  function automatic logic [7:0] rand_noise();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: b = dtfp_pkg::CH_POINT;
      1: b = dtfp_pkg::CH_PLUS;
      2: b = dtfp_pkg::CH_MINUS;
      3: b = 8'($urandom_range(0, 255));
      default: b = rand_digit();
    endcase
    return b;
  endfunction

  // Offer one character after a random gap and hold it until taken
  task automatic send_char(input logic [7:0] ch, input logic last_ch);
    int                 gap;
    dtfp_pkg::in_item_t item;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.character = ch;
    item.last      = last_ch;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    chars_sent++;
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++) begin
      send_char(text_q[i], i == text_q.size() - 1);
    end
    texts_sent++;
  endtask

  task automatic send_word(input string s);
    int i;
    text_q.delete();
    for (i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
    end
    send_text();
  endtask

  // Drop valid and wait until every owed result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed numbers with random digits, the rest broken or noise
  task automatic build_random_text();
    int         kind;
    int         n_int;
    int         n_frac;
    int         i;
    logic       has_point;
    logic [7:0] ch;
    logic [7:0] lead;
    text_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 12)) text_q.push_back(rand_noise());
    end else begin
      case ($urandom_range(0, 2))
        1: text_q.push_back(dtfp_pkg::CH_PLUS);
        2: text_q.push_back(dtfp_pkg::CH_MINUS);
        default: ;
      endcase
      if (kind == 7) begin
        n_int  = $urandom_range(0, INT_DIGITS + 2);
        n_frac = $urandom_range(0, FRAC_DIGITS + 2);
      end else begin
        n_int  = $urandom_range(0, INT_DIGITS);
        n_frac = $urandom_range(0, FRAC_DIGITS);
      end
      has_point = (n_frac != 0) || ($urandom_range(0, 1) == 1);
      for (i = 0; i < n_int; i++) begin
        ch = rand_digit();
        // Lean three-digit integers towards the range limit
        if ((i == 0) && (n_int == INT_DIGITS) && ($urandom_range(0, 1) == 1)) begin
          lead = 8'($urandom_range(0, 2));
          ch   = dtfp_pkg::CH_ZERO + lead;
        end
        text_q.push_back(ch);
      end
      if (has_point) begin
        text_q.push_back(dtfp_pkg::CH_POINT);
      end
      for (i = 0; i < n_frac; i++) begin
        text_q.push_back(rand_digit());
      end
      if (text_q.size() == 0) begin
        text_q.push_back(rand_digit());
      end
      if (kind == 8) begin
        text_q[$urandom_range(0, text_q.size() - 1)] = rand_noise();
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    int text_no;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: range limits, wrap, empty parts, each fault kind
    send_word("-256.9");
    send_word(".");
    send_word("-");
    send_word("256");
    send_word("1234");
    send_word(".12345");
    send_word("..");
    send_word("1+");
    text_q.delete();
    text_q.push_back(8'h00);
    send_text();
    send_word("+255.99999");
    wait_drained();

    // Random texts in runs, with and without idling on each side
    text_no = 0;
    while (chars_sent < RANDOM_CHARS) begin
      if (text_no % TEXTS_PER_RUN == 0) begin
        if ((text_no != 0) && ($urandom_range(0, 2) == 0)) begin
          wait_drained();
        end
        send_idle = $urandom_range(0, 3) != 0;
        recv_idle = $urandom_range(0, 3) != 0;
      end
      build_random_text();
      send_text();
      text_no++;
    end
    wait_drained();

    $display("summary: %0d characters in %0d texts, %0d results compared",
             chars_sent, texts_sent, results);
    $display("summary: status codes seen, one bit per code from 0 upwards: %b",
             status_seen);
    if ((fail_count == 0) && (pending == 0)) begin
      $display("decimal_text_to_fixed_point_core_tb: done, clean");
    end else begin
      $display("decimal_text_to_fixed_point_core_tb: done, errors");
    end
    $finish;
  end

endmodule
